/* src/srws_pkg.sv */
package srws_pkg;

  // Frame and window geometry. WINDOW_FRAMES must be a power of two no larger than 32.
  localparam int FRAME_BYTES   = 240;
  localparam int WINDOW_FRAMES = 32;
  localparam int WIN_SHIFT     = $clog2(WINDOW_FRAMES);

  localparam int SIZE_W      = 24;
  localparam int FRAME_CNT_W = 17;
  localparam int WIN_W       = 16;
  localparam int TMO_W       = 12;
  localparam int RETRY_W     = 5;
  localparam int MASK_W      = 32;
  localparam int ERR_W       = 8;
  localparam int FL_W        = $clog2(WINDOW_FRAMES + 1);
  localparam int BYTE_W      = $clog2(WINDOW_FRAMES * FRAME_BYTES + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_SIZE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_TIMEOUT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_TIMEOUT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_RETRIES  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_RETRIES  = 3'd4;

  localparam logic [TMO_W-1:0]   WIN_TIMEOUT_RST = 12'd500;
  localparam logic [TMO_W-1:0]   END_TIMEOUT_RST = 12'd2000;
  localparam logic [RETRY_W-1:0] WIN_RETRIES_RST = 5'd20;
  localparam logic [RETRY_W-1:0] END_RETRIES_RST = 5'd8;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_WINDOW = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_BEGIN  = 2'd1;
  localparam logic [1:0] ACT_WINDOW = 2'd2;
  localparam logic [1:0] ACT_END    = 2'd3;

  localparam logic [2:0] OUTC_RUN     = 3'd0;
  localparam logic [2:0] OUTC_DONE    = 3'd1;
  localparam logic [2:0] OUTC_DEV_ERR = 3'd2;
  localparam logic [2:0] OUTC_UNREACH = 3'd3;
  localparam logic [2:0] OUTC_REJECT  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PUSH = 2'd1,
    PH_DONE = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        ack_kind;
    logic [WIN_W-1:0]  ack_window;
    logic [MASK_W-1:0] ack_missing;
    logic [ERR_W-1:0]  ack_error_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [WIN_W-1:0]  window_index;
    logic [MASK_W-1:0] frame_mask;
    logic [SIZE_W-1:0] acked_bytes;
    logic [2:0]        outcome;
    logic [ERR_W-1:0]  device_error;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [SIZE_W-1:0]      image_size;
    logic [FRAME_CNT_W-1:0] frames;
    logic [WIN_W-1:0]       windows;
    logic [TMO_W-1:0]       win_timeout;
    logic [TMO_W-1:0]       end_timeout;
    logic [RETRY_W-1:0]     win_retries;
    logic [RETRY_W-1:0]     end_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

endpackage

/* src/srws_cfg.sv */
module srws_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srws_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [srws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output srws_pkg::cfg_t                   cfg
);
  import srws_pkg::*;

  // Frame count is ceil(size / FRAME_BYTES), done as an exact reciprocal multiply.
  localparam int X_W    = SIZE_W + 1;
  localparam int SH     = X_W + $clog2(FRAME_BYTES);
  localparam int RCP_W  = X_W + 2;
  localparam longint unsigned RCP_L =
    ((64'd1 << SH) + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_L);
  localparam int P_W    = X_W + RCP_W;

  logic [SIZE_W-1:0]      image_size_r;
  logic [FRAME_CNT_W-1:0] frames_r, frames_nxt;
  logic [WIN_W-1:0]       windows_r, windows_nxt;
  logic [TMO_W-1:0]       win_timeout_r, end_timeout_r;
  logic [RETRY_W-1:0]     win_retries_r, end_retries_r;

  logic [X_W-1:0]         size_up;
  logic [P_W-1:0]         prod;
  logic [X_W-1:0]         quot;
  logic [FRAME_CNT_W:0]   win_up;

  always_comb begin
    size_up  = X_W'(cfg_wdata[SIZE_W-1:0]) + X_W'(FRAME_BYTES - 1);
    prod     = P_W'(size_up) * P_W'(RECIP);
    quot     = X_W'(prod >> SH);
    if (quot > X_W'({FRAME_CNT_W{1'b1}})) begin
      frames_nxt = {FRAME_CNT_W{1'b1}};
    end else begin
      frames_nxt = quot[FRAME_CNT_W-1:0];
    end
    win_up      = (FRAME_CNT_W + 1)'(frames_nxt) + (FRAME_CNT_W + 1)'(WINDOW_FRAMES - 1);
    windows_nxt = WIN_W'(win_up >> WIN_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= '0;
      frames_r      <= '0;
      windows_r     <= '0;
      win_timeout_r <= WIN_TIMEOUT_RST;
      end_timeout_r <= END_TIMEOUT_RST;
      win_retries_r <= WIN_RETRIES_RST;
      end_retries_r <= END_RETRIES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_SIZE: begin
          image_size_r <= cfg_wdata[SIZE_W-1:0];
          frames_r     <= frames_nxt;
          windows_r    <= windows_nxt;
        end
        CFG_WIN_TIMEOUT: win_timeout_r <= cfg_wdata[TMO_W-1:0];
        CFG_END_TIMEOUT: end_timeout_r <= cfg_wdata[TMO_W-1:0];
        CFG_WIN_RETRIES: win_retries_r <= cfg_wdata[RETRY_W-1:0];
        CFG_END_RETRIES: end_retries_r <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.image_size  = image_size_r;
  assign cfg.frames      = frames_r;
  assign cfg.windows     = windows_r;
  assign cfg.win_timeout = win_timeout_r;
  assign cfg.end_timeout = end_timeout_r;
  assign cfg.win_retries = win_retries_r;
  assign cfg.end_retries = end_retries_r;

endmodule

/* src/srws_core.sv */
module srws_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  srws_pkg::in_word_t item,
  input  srws_pkg::cfg_t     cfg,
  output srws_pkg::push_t    push
);
  import srws_pkg::*;

  localparam int FW = WIN_W + WIN_SHIFT;

  function automatic logic [FL_W-1:0] frames_left(input logic [FRAME_CNT_W-1:0] fc,
                                                  input logic [WIN_W-1:0] w);
    logic [FW-1:0] first;
    logic [FW-1:0] ext;
    logic [FW-1:0] rem;
    first = FW'(w) << WIN_SHIFT;
    ext   = FW'(fc);
    rem   = (ext > first) ? (ext - first) : '0;
    if (rem > FW'(WINDOW_FRAMES)) begin
      frames_left = FL_W'(WINDOW_FRAMES);
    end else begin
      frames_left = rem[FL_W-1:0];
    end
  endfunction

  function automatic logic [MASK_W-1:0] full_mask(input logic [FL_W-1:0] n);
    logic [WINDOW_FRAMES:0] one_hot;
    one_hot   = (WINDOW_FRAMES + 1)'(1) << n;
    full_mask = MASK_W'(one_hot - 1'b1);
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic [WIN_W-1:0]       cur_win_r, cur_win_nxt;
  logic [WIN_W-1:0]       windows_r, windows_nxt;
  logic [FRAME_CNT_W-1:0] frames_r, frames_nxt;
  logic [RETRY_W-1:0]     retry_r, retry_nxt;
  logic                   end_sent_r, end_sent_nxt;
  logic                   got_ack_r, got_ack_nxt;
  logic [SIZE_W-1:0]      conf_r, conf_nxt;
  logic [TMO_W-1:0]       cnt_r, cnt_nxt;
  logic [ERR_W-1:0]       err_r, err_nxt;

  logic [1:0]             n_res;
  logic [1:0]             act0, act1;
  logic [2:0]             outc0;
  logic                   use_miss;

  logic [FL_W-1:0]        fl_cur;
  logic [BYTE_W-1:0]      new_bytes;
  logic [SIZE_W:0]        byte_sum;
  logic [WIN_W-1:0]       cur_inc;
  logic [RETRY_W:0]       retry_inc;
  logic [RETRY_W-1:0]     limit;
  logic [FL_W-1:0]        fl_nxt;
  logic [MASK_W-1:0]      mask_nxt;

  always_comb begin
    fl_cur    = frames_left(frames_r, cur_win_r);
    new_bytes = BYTE_W'(fl_cur) * BYTE_W'(FRAME_BYTES);
    byte_sum  = (SIZE_W + 1)'(conf_r) + (SIZE_W + 1)'(new_bytes);
    cur_inc   = (cur_win_r == {WIN_W{1'b1}}) ? cur_win_r : cur_win_r + 1'b1;
    retry_inc = (RETRY_W + 1)'(retry_r) + 1'b1;
    limit     = end_sent_r ? cfg.end_retries : cfg.win_retries;
  end

  // Next state, plus the pattern of result words the item causes.
  always_comb begin
    phase_nxt    = phase_r;
    cur_win_nxt  = cur_win_r;
    windows_nxt  = windows_r;
    frames_nxt   = frames_r;
    retry_nxt    = retry_r;
    end_sent_nxt = end_sent_r;
    got_ack_nxt  = got_ack_r;
    conf_nxt     = conf_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    n_res        = 2'd0;
    act0         = ACT_NONE;
    act1         = ACT_WINDOW;
    outc0        = OUTC_RUN;
    use_miss     = 1'b0;
    if (go) begin
      case (item.opcode)
        OP_START: begin
          if (cfg.image_size == '0) begin
            n_res = 2'd1;
            outc0 = OUTC_REJECT;
          end else begin
            frames_nxt   = cfg.frames;
            windows_nxt  = cfg.windows;
            cur_win_nxt  = '0;
            got_ack_nxt  = 1'b0;
            end_sent_nxt = 1'b0;
            retry_nxt    = '0;
            conf_nxt     = '0;
            err_nxt      = '0;
            phase_nxt    = PH_PUSH;
            cnt_nxt      = cfg.win_timeout;
            n_res        = 2'd2;
            act0         = ACT_BEGIN;
          end
        end
        OP_ACK: begin
          if (phase_r == PH_PUSH) begin
            got_ack_nxt = 1'b1;
            retry_nxt   = '0;
            if (item.ack_kind == KIND_OK) begin
              conf_nxt  = cfg.image_size;
              phase_nxt = PH_DONE;
              n_res     = 2'd1;
              outc0     = OUTC_DONE;
            end else if (item.ack_kind != KIND_WINDOW) begin
              // Busy, error and unknown kinds all end the transfer.
              err_nxt   = item.ack_error_code;
              phase_nxt = PH_FAIL;
              n_res     = 2'd1;
              outc0     = OUTC_DEV_ERR;
            end else if (item.ack_window == cur_win_r) begin
              n_res = 2'd1;
              if (item.ack_missing == '0) begin
                conf_nxt    = (byte_sum > (SIZE_W + 1)'(cfg.image_size)) ?
                              cfg.image_size : byte_sum[SIZE_W-1:0];
                cur_win_nxt = cur_inc;
                if (cur_inc >= windows_r) begin
                  end_sent_nxt = 1'b1;
                  cnt_nxt      = cfg.end_timeout;
                  act0         = ACT_END;
                end else begin
                  cnt_nxt = cfg.win_timeout;
                  act0    = ACT_WINDOW;
                end
              end else begin
                cnt_nxt  = cfg.win_timeout;
                act0     = ACT_WINDOW;
                use_miss = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (phase_r == PH_PUSH) begin
            if (cnt_r > TMO_W'(1)) begin
              cnt_nxt = cnt_r - 1'b1;
            end else begin
              cnt_nxt   = '0;
              retry_nxt = retry_inc[RETRY_W] ? {RETRY_W{1'b1}} : retry_inc[RETRY_W-1:0];
              if (retry_inc > (RETRY_W + 1)'(limit)) begin
                phase_nxt = PH_FAIL;
                n_res     = 2'd1;
                outc0     = OUTC_UNREACH;
              end else if (end_sent_r) begin
                cnt_nxt = cfg.end_timeout;
                n_res   = 2'd1;
                act0    = ACT_END;
              end else if (!got_ack_r) begin
                cnt_nxt = cfg.win_timeout;
                n_res   = 2'd2;
                act0    = ACT_BEGIN;
              end else begin
                cnt_nxt = cfg.win_timeout;
                n_res   = 2'd1;
                act0    = ACT_WINDOW;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result words, built from the updated state.
  always_comb begin
    fl_nxt   = frames_left(frames_nxt, cur_win_nxt);
    mask_nxt = full_mask(fl_nxt);
    if (use_miss) begin
      mask_nxt = mask_nxt & item.ack_missing;
    end

    push.cnt = n_res;

    push.w0.action       = act0;
    push.w0.window_index = (act0 == ACT_WINDOW) ? cur_win_nxt : '0;
    push.w0.frame_mask   = (act0 == ACT_WINDOW) ? mask_nxt : '0;
    push.w0.acked_bytes  = conf_nxt;
    push.w0.outcome      = outc0;
    push.w0.device_error = (outc0 == OUTC_DEV_ERR) ? err_nxt : '0;
    push.w0.last         = (n_res == 2'd1);

    push.w1.action       = act1;
    push.w1.window_index = cur_win_nxt;
    push.w1.frame_mask   = mask_nxt;
    push.w1.acked_bytes  = conf_nxt;
    push.w1.outcome      = OUTC_RUN;
    push.w1.device_error = '0;
    push.w1.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cur_win_r  <= '0;
      windows_r  <= '0;
      frames_r   <= '0;
      retry_r    <= '0;
      end_sent_r <= 1'b0;
      got_ack_r  <= 1'b0;
      conf_r     <= '0;
      cnt_r      <= '0;
      err_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cur_win_r  <= cur_win_nxt;
      windows_r  <= windows_nxt;
      frames_r   <= frames_nxt;
      retry_r    <= retry_nxt;
      end_sent_r <= end_sent_nxt;
      got_ack_r  <= got_ack_nxt;
      conf_r     <= conf_nxt;
      cnt_r      <= cnt_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

/* src/srws_out_fifo.sv */
module srws_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  srws_pkg::push_t     push,
  input  logic                pop,
  output logic                room,
  output logic                valid,
  output srws_pkg::out_word_t head
);
  import srws_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  out_word_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic [PTR_W-1:0]   wr_ptr_p1;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(push.cnt) - (PTR_W + 1)'(pop);
  end

  // Two free slots are needed since an item may leave two words.
  assign room  = (count_r <= (PTR_W + 1)'(DEPTH - 2));
  assign valid = (count_r != '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.w0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/selective_repeat_window_sender.sv */
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_word  (srws_pkg::in_word_t)
// out_      output     out_valid / out_stall out_word (srws_pkg::out_word_t)
// cfg_      input      cfg_we                cfg_addr, cfg_wdata
//
// An accepted word is held in the input register and processed from there once the queue
// has room, so a new word can be taken every cycle while the queue has room. Results
// leave through a four-word queue, one per cycle while out_stall is low; processing
// waits while fewer than two queue slots are free, as a word may have two results.
// Synchronous reset clears the core and queue and sets cfg defaults; no clearing pass.
// A stalled output holds back input once three queue slots are taken and a word is waiting.
module selective_repeat_window_sender (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  srws_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output srws_pkg::out_word_t              out_word,
  input  logic                             cfg_we,
  input  logic [srws_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [srws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import srws_pkg::*;

  in_word_t in_word_r;
  logic     in_vld_r, in_vld_nxt;
  logic     room;
  logic     go;
  logic     in_take;
  cfg_t     cfg;
  push_t    push;

  assign go       = in_vld_r & room;
  assign in_stall = in_vld_r & ~room;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
  end

  srws_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srws_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_word_r),
    .cfg   (cfg),
    .push  (push)
  );

  srws_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_valid & ~out_stall),
    .room  (room),
    .valid (out_valid),
    .head  (out_word)
  );

endmodule

/* src/srws_checker.sv */
module srws_assertions (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_stall,
  input  logic                out_valid,
  input  logic                out_stall,
  input  srws_pkg::out_word_t out_word
);
  import srws_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_final_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.outcome != OUTC_RUN |->
      out_word.action == ACT_NONE && out_word.last)
    else $error("outcome word carries a command or is not last");

  a_mask_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.action != ACT_WINDOW |->
      out_word.frame_mask == '0 && out_word.window_index == '0)
    else $error("frame mask or window on a non-window command");

  a_dev_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.device_error != '0 |-> out_word.outcome == OUTC_DEV_ERR)
    else $error("device error code without device error outcome");

endmodule

bind selective_repeat_window_sender srws_assertions u_srws_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
